// ----- rtl/tte_pkg.sv -----
// Shared constants for the tap tempo estimator.
// Used by every module under rtl; it depends on nothing else.
package tte_pkg;

    localparam int NUM_CHANNELS_DEFAULT  = 3;
    localparam int HISTORY_DEPTH_DEFAULT = 5;

    localparam int TIME_W      = 32;
    localparam int INTERVAL_W  = 12;
    localparam int TEMPO_W     = 11;
    localparam int CFG_W       = 12;
    localparam int CFG_INDEX_W = 2;
    localparam int DIGIT_W     = 4;

    localparam int TENTHS_SCALE = 600000;
    localparam int TEMPO_MIN    = 400;
    localparam int TEMPO_MAX    = 2000;

    localparam logic [CFG_W-1:0] MIN_INTERVAL_RESET = 12'd100;
    localparam logic [CFG_W-1:0] MAX_INTERVAL_RESET = 12'd3000;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_INTERVAL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_INTERVAL = 2'd1;

endpackage

// ----- rtl/tte_serial_sub.sv -----
// Digit-serial 32-bit subtractor for tap intervals, one digit per cycle.
// Depends on tte_pkg.
module tte_serial_sub
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [tte_pkg::TIME_W-1:0] minuend,
    input  logic [tte_pkg::TIME_W-1:0] subtrahend,
    output logic                       done,
    output logic [tte_pkg::TIME_W-1:0] diff
);

    localparam int N_DIGITS = tte_pkg::TIME_W / tte_pkg::DIGIT_W;
    localparam int DCNT_W   = $clog2(N_DIGITS);

    logic [tte_pkg::TIME_W-1:0]  a_sr_reg;
    logic [tte_pkg::TIME_W-1:0]  b_sr_reg;
    logic [tte_pkg::TIME_W-1:0]  diff_sr_reg;
    logic                        borrow_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [DCNT_W-1:0]           dcnt_reg;
    logic [tte_pkg::DIGIT_W:0]   digit_step;

    assign digit_step = {1'b0, a_sr_reg[tte_pkg::DIGIT_W-1:0]}
                      - {1'b0, b_sr_reg[tte_pkg::DIGIT_W-1:0]}
                      - {{tte_pkg::DIGIT_W{1'b0}}, borrow_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            dcnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                dcnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                dcnt_reg <= dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_W'(N_DIGITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_sr_reg   <= minuend;
            b_sr_reg   <= subtrahend;
            borrow_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            a_sr_reg    <= a_sr_reg >> tte_pkg::DIGIT_W;
            b_sr_reg    <= b_sr_reg >> tte_pkg::DIGIT_W;
            borrow_reg  <= digit_step[tte_pkg::DIGIT_W];
            diff_sr_reg <= {digit_step[tte_pkg::DIGIT_W-1:0],
                            diff_sr_reg[tte_pkg::TIME_W-1:tte_pkg::DIGIT_W]};
        end
    end

    assign done = done_reg;
    assign diff = diff_sr_reg;

endmodule

// ----- rtl/tte_ring.sv -----
// Interval history memory for all channels, one write and one registered read port.
// Depends on tte_pkg.
module tte_ring
#(
    parameter int NUM_CHANNELS  = tte_pkg::NUM_CHANNELS_DEFAULT,
    parameter int HISTORY_DEPTH = tte_pkg::HISTORY_DEPTH_DEFAULT,
    localparam int ENTRIES = NUM_CHANNELS * HISTORY_DEPTH,
    localparam int ADDR_W  = $clog2(ENTRIES)
)
(
    input  logic                           clk,
    input  logic                           we,
    input  logic [ADDR_W-1:0]              waddr,
    input  logic [tte_pkg::INTERVAL_W-1:0] wdata,
    input  logic                           re,
    input  logic [ADDR_W-1:0]              raddr,
    output logic [tte_pkg::INTERVAL_W-1:0] rdata
);

    logic [tte_pkg::INTERVAL_W-1:0] mem [ENTRIES];
    logic [tte_pkg::INTERVAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/tte_divider.sv -----
// Bit-serial restoring divider: floor(600000 * n / sum), clamped to the tempo range.
// Depends on tte_pkg.
module tte_divider
#(
    parameter int HISTORY_DEPTH = tte_pkg::HISTORY_DEPTH_DEFAULT,
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1),
    localparam int SUM_W = tte_pkg::INTERVAL_W + CNT_W
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [CNT_W-1:0]            count,
    input  logic [SUM_W-1:0]            divisor,
    output logic                        done,
    output logic [tte_pkg::TEMPO_W-1:0] tempo
);

    localparam int NUM_W  = $clog2(tte_pkg::TENTHS_SCALE * HISTORY_DEPTH + 1);
    localparam int STEP_W = $clog2(NUM_W + 1);
    localparam logic [NUM_W-1:0] SCALE_N = NUM_W'(tte_pkg::TENTHS_SCALE);
    localparam logic [NUM_W-1:0] Q_MAX   = NUM_W'(tte_pkg::TEMPO_MAX);
    localparam logic [NUM_W-1:0] Q_MIN   = NUM_W'(tte_pkg::TEMPO_MIN);

    logic                        busy_reg;
    logic                        fin_reg;
    logic                        done_reg;
    logic [STEP_W-1:0]           step_reg;
    logic [NUM_W-1:0]            num_reg;
    logic [NUM_W-1:0]            quo_reg;
    logic [SUM_W-1:0]            rem_reg;
    logic [SUM_W-1:0]            div_reg;
    logic [tte_pkg::TEMPO_W-1:0] tempo_reg;
    logic [SUM_W:0]              trial;
    logic [SUM_W:0]              rem_step;
    logic                        q_bit;

    always_comb
    begin
        trial    = {rem_reg, num_reg[NUM_W-1]};
        q_bit    = (trial >= {1'b0, div_reg});
        rem_step = q_bit ? (trial - {1'b0, div_reg}) : trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= SCALE_N * NUM_W'(count);
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_reg << 1;
            rem_reg <= rem_step[SUM_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], q_bit};
        end
        if (fin_reg)
        begin
            if (quo_reg > Q_MAX)
            begin
                tempo_reg <= tte_pkg::TEMPO_W'(tte_pkg::TEMPO_MAX);
            end
            else if (quo_reg < Q_MIN)
            begin
                tempo_reg <= tte_pkg::TEMPO_W'(tte_pkg::TEMPO_MIN);
            end
            else
            begin
                tempo_reg <= quo_reg[tte_pkg::TEMPO_W-1:0];
            end
        end
    end

    assign done  = done_reg;
    assign tempo = tempo_reg;

endmodule

// ----- rtl/tap_tempo_estimator.sv -----
// Top level of the tap tempo estimator: channel state, control sequencer, output register.
// Depends on tte_pkg, tte_serial_sub, tte_ring and tte_divider.
//
// Each transfer on the s_ channel is one tap: a channel number and a millisecond
// timestamp. A channel's first tap only records its time. Later taps measure the
// interval since the previous tap; an interval outside the configured limits
// clears that channel's history. From the second valid interval on, one transfer
// leaves on the m_ channel with the channel and its tempo in tenths of BPM,
// clamped to 400..2000. Taps on channels beyond the configured count are dropped.
// Register writes on the cfg_ channel are taken in any cycle (index 0 sets the
// shortest interval, index 1 the longest); they are meant for idle periods.
// First and dropped taps are done in their transfer cycle; a rejected or first
// stored interval holds s_tready low through the serial subtract and the range
// check. A tap that yields a tempo raises m_tvalid after the 8-digit serial
// subtract, the range check, the history sum read one entry per cycle over the n
// stored intervals and, at default parameters, the 22-step serial division;
// s_tready returns high in the same cycle that m_tvalid presents the tempo. One
// tap is worked on at a time. A finished result waits in the output register while
// the receiver stalls and the next tap is taken; a second tempo then waits with
// s_tready low. Reset clears all channel history and restores the limits to 100 ms and 3000 ms.
module tap_tempo_estimator
#(
    parameter int NUM_CHANNELS  = tte_pkg::NUM_CHANNELS_DEFAULT,
    parameter int HISTORY_DEPTH = tte_pkg::HISTORY_DEPTH_DEFAULT,
    localparam int CH_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
    localparam int IN_DATA_W  = ((CH_W + tte_pkg::TIME_W + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((CH_W + tte_pkg::TEMPO_W + 7) / 8) * 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [IN_DATA_W-1:0]            s_tdata,   // tap_channel, time_ms
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [OUT_DATA_W-1:0]           m_tdata,   // out_channel, tempo_tenths
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tte_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tte_pkg::CFG_W-1:0]       cfg_data
);

    localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int SLOT_W  = $clog2(HISTORY_DEPTH);
    localparam int SUM_W   = tte_pkg::INTERVAL_W + CNT_W;
    localparam int ADDR_W  = $clog2(NUM_CHANNELS * HISTORY_DEPTH);
    localparam int TIME_W  = tte_pkg::TIME_W;
    localparam int IV_W    = tte_pkg::INTERVAL_W;
    localparam logic [CH_W:0]      NCH_C   = (CH_W + 1)'(NUM_CHANNELS);
    localparam logic [CNT_W-1:0]   DEPTH_C = CNT_W'(HISTORY_DEPTH);
    localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);
    localparam logic [ADDR_W-1:0]  DEPTH_A = ADDR_W'(HISTORY_DEPTH);

    typedef enum logic [5:0]
    {
        ST_IDLE  = 6'b000001,
        ST_SUB   = 6'b000010,
        ST_CHECK = 6'b000100,
        ST_SUM   = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [tte_pkg::CFG_W-1:0]   min_reg;
    logic [tte_pkg::CFG_W-1:0]   max_reg;
    logic [TIME_W-1:0]           last_time_reg [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]     seen_reg;
    logic [CNT_W-1:0]            count_reg [NUM_CHANNELS];
    logic [SLOT_W-1:0]           slot_reg [NUM_CHANNELS];
    logic [CH_W-1:0]             ch_reg;
    logic [TIME_W-1:0]           now_reg;
    logic [CNT_W-1:0]            n_reg;
    logic [CNT_W-1:0]            rd_idx_reg;
    logic                        rd_valid_reg;
    logic [SUM_W-1:0]            sum_reg;
    logic                        m_valid_reg;
    logic [OUT_DATA_W-1:0]       m_data_reg;

    logic [CH_W-1:0]             s_ch;
    logic [TIME_W-1:0]           s_time;
    logic                        in_fire;
    logic                        ch_ok;
    logic                        start_sub;
    logic                        sub_done;
    logic [TIME_W-1:0]           sub_diff;
    logic                        in_range;
    logic [CNT_W-1:0]            count_cur;
    logic [CNT_W-1:0]            cnt_inc;
    logic [SLOT_W-1:0]           slot_cur;
    logic [SLOT_W-1:0]           slot_adv;
    logic [ADDR_W-1:0]           base_addr;
    logic                        ring_we;
    logic                        ring_re;
    logic [IV_W-1:0]             ring_rdata;
    logic                        sum_finish;
    logic                        div_done;
    logic [tte_pkg::TEMPO_W-1:0] div_tempo;
    logic                        out_free;

    assign s_ch      = s_tdata[CH_W-1:0];
    assign s_time    = s_tdata[CH_W +: TIME_W];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign ch_ok     = ({1'b0, s_ch} < NCH_C);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    always_comb
    begin
        start_sub = 1'b0;
        if (in_fire && ch_ok)
        begin
            start_sub = seen_reg[s_ch];
        end
    end

    always_comb
    begin
        count_cur  = count_reg[ch_reg];
        slot_cur   = slot_reg[ch_reg];
        cnt_inc    = (count_cur == DEPTH_C) ? count_cur : count_cur + 1'b1;
        slot_adv   = (slot_cur == LAST_SLOT) ? '0 : slot_cur + 1'b1;
        in_range   = (sub_diff[TIME_W-1:IV_W] == '0)
                  && (sub_diff[IV_W-1:0] >= min_reg)
                  && (sub_diff[IV_W-1:0] <= max_reg);
        base_addr  = ADDR_W'(ch_reg) * DEPTH_A;
        ring_we    = (state_reg == ST_CHECK) && in_range;
        ring_re    = (state_reg == ST_SUM) && (rd_idx_reg != n_reg);
        sum_finish = (rd_idx_reg == n_reg) && !rd_valid_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_sub)
                begin
                    state_next = ST_SUB;
                end
            end
            ST_SUB:
            begin
                if (sub_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (in_range && (cnt_inc >= CNT_W'(2)))
                begin
                    state_next = ST_SUM;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SUM:
            begin
                if (sum_finish)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            min_reg      <= tte_pkg::MIN_INTERVAL_RESET;
            max_reg      <= tte_pkg::MAX_INTERVAL_RESET;
            seen_reg     <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                last_time_reg[i] <= '0;
                count_reg[i]     <= '0;
                slot_reg[i]      <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid)
            begin
                case (cfg_index)
                    tte_pkg::CFG_MIN_INTERVAL: min_reg <= cfg_data;
                    tte_pkg::CFG_MAX_INTERVAL: max_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (in_fire && ch_ok && !seen_reg[s_ch])
            begin
                seen_reg[s_ch]      <= 1'b1;
                last_time_reg[s_ch] <= s_time;
                count_reg[s_ch]     <= '0;
                slot_reg[s_ch]      <= '0;
            end

            if (state_reg == ST_CHECK)
            begin
                last_time_reg[ch_reg] <= now_reg;
                if (in_range)
                begin
                    count_reg[ch_reg] <= cnt_inc;
                    slot_reg[ch_reg]  <= slot_adv;
                end
                else
                begin
                    count_reg[ch_reg] <= '0;
                    slot_reg[ch_reg]  <= '0;
                end
            end

            rd_valid_reg <= ring_re;

            if ((state_reg == ST_OUT) && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ch_reg  <= s_ch;
            now_reg <= s_time;
        end
        if (state_reg == ST_CHECK)
        begin
            n_reg      <= cnt_inc;
            rd_idx_reg <= '0;
            sum_reg    <= '0;
        end
        else if (state_reg == ST_SUM)
        begin
            if (ring_re)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            if (rd_valid_reg)
            begin
                sum_reg <= sum_reg + SUM_W'(ring_rdata);
            end
        end
        if ((state_reg == ST_OUT) && out_free)
        begin
            m_data_reg <= OUT_DATA_W'({div_tempo, ch_reg});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    tte_serial_sub u_sub
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start_sub),
        .minuend    (s_time),
        .subtrahend (last_time_reg[s_ch]),
        .done       (sub_done),
        .diff       (sub_diff)
    );

    tte_ring
    #(
        .NUM_CHANNELS  (NUM_CHANNELS),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    )
    u_ring
    (
        .clk   (clk),
        .we    (ring_we),
        .waddr (base_addr + ADDR_W'(slot_cur)),
        .wdata (sub_diff[IV_W-1:0]),
        .re    (ring_re),
        .raddr (base_addr + ADDR_W'(rd_idx_reg[SLOT_W-1:0])),
        .rdata (ring_rdata)
    );

    tte_divider
    #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    )
    u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   ((state_reg == ST_SUM) && sum_finish),
        .count   (n_reg),
        .divisor (sum_reg),
        .done    (div_done),
        .tempo   (div_tempo)
    );

    // A delivered tempo always lies inside the clamp range.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |->
            (m_data_reg[CH_W +: tte_pkg::TEMPO_W] >= tte_pkg::TEMPO_W'(tte_pkg::TEMPO_MIN))
         && (m_data_reg[CH_W +: tte_pkg::TEMPO_W] <= tte_pkg::TEMPO_W'(tte_pkg::TEMPO_MAX)))
        else $error("tempo outside clamp range");

    assert property (@(posedge clk) disable iff (!rst_n)
        sub_done |-> (state_reg == ST_SUB))
        else $error("subtractor finished outside the subtract phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |-> (count_reg[ch_reg] <= DEPTH_C))
        else $error("interval count above history depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> ((state_reg == ST_IDLE) || (state_reg == ST_SUB)))
        else $error("tap transfer led to an unexpected state");

endmodule

// ----- tb/sv/tap_tempo_estimator_test.sv -----
// Self-checking testbench for tap_tempo_estimator: drives tap transfers and limit writes,
// predicts every tempo result and compares it with what leaves the block.
// Depends on tte_pkg and the tap_tempo_estimator RTL.
`timescale 1ns / 100ps

module tap_tempo_estimator_test;

    localparam int NCH        = tte_pkg::NUM_CHANNELS_DEFAULT;
    localparam int DEPTH      = tte_pkg::HISTORY_DEPTH_DEFAULT;
    localparam int CH_W       = 2;
    localparam int TIME_W     = tte_pkg::TIME_W;
    localparam int TEMPO_W    = tte_pkg::TEMPO_W;
    localparam int CFG_W      = tte_pkg::CFG_W;
    localparam int IN_W       = ((CH_W + TIME_W + 7) / 8) * 8;
    localparam int OUT_W      = ((CH_W + TEMPO_W + 7) / 8) * 8;
    localparam int SETTLE_CYC = 100;
    localparam int CYCLE_CAP  = 500000;
    localparam int PHASE_ITEMS = 150;

    typedef enum {FLOW_FREE, FLOW_SEND_GAPS, FLOW_RECV_STALLS, FLOW_BOTH} flow_t;

    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic [TEMPO_W-1:0] tempo;
    } tempo_result_t;

    class tap_tempo_tracker;
        logic [CFG_W-1:0]               lo_ms;
        logic [CFG_W-1:0]               hi_ms;
        logic [TIME_W-1:0]              last_ms [NCH];
        bit                             seen [NCH];
        int unsigned                    count [NCH];
        int unsigned                    slot [NCH];
        logic [tte_pkg::INTERVAL_W-1:0] ring [NCH][DEPTH];
        tempo_result_t                  expected_tempos [$];
        int                             errors;

        function new();
            lo_ms  = tte_pkg::MIN_INTERVAL_RESET;
            hi_ms  = tte_pkg::MAX_INTERVAL_RESET;
            errors = 0;
            for (int c = 0; c < NCH; c++)
            begin
                last_ms[c] = '0;
                seen[c]    = 1'b0;
                count[c]   = 0;
                slot[c]    = 0;
            end
        endfunction

        function void set_limit(logic [tte_pkg::CFG_INDEX_W-1:0] index,
                                logic [CFG_W-1:0] value);
            if (index == tte_pkg::CFG_MIN_INTERVAL)
                lo_ms = value;
            else if (index == tte_pkg::CFG_MAX_INTERVAL)
                hi_ms = value;
        endfunction

        function int pending();
            return expected_tempos.size();
        endfunction

        function void note_tap(logic [CH_W-1:0] ch, logic [TIME_W-1:0] now);
            logic [TIME_W-1:0] gap;
            longint unsigned   total;
            longint unsigned   quot;
            tempo_result_t     res;
            if (ch >= NCH)
                return;
            if (!seen[ch])
            begin
                seen[ch]    = 1'b1;
                last_ms[ch] = now;
                count[ch]   = 0;
                slot[ch]    = 0;
                return;
            end
            gap         = now - last_ms[ch];
            last_ms[ch] = now;
            if (gap < lo_ms || gap > hi_ms)
            begin
                count[ch] = 0;
                slot[ch]  = 0;
                return;
            end
            ring[ch][slot[ch]] = gap[tte_pkg::INTERVAL_W-1:0];
            slot[ch] = (slot[ch] + 1 >= DEPTH) ? 0 : slot[ch] + 1;
            if (count[ch] < DEPTH)
                count[ch]++;
            if (count[ch] < 2)
                return;
            total = 0;
            for (int i = 0; i < count[ch]; i++)
                total += ring[ch][i];
            if (total == 0)
                quot = tte_pkg::TEMPO_MAX;
            else
                quot = (longint'(tte_pkg::TENTHS_SCALE) * count[ch]) / total;
            if (quot < tte_pkg::TEMPO_MIN)
                quot = tte_pkg::TEMPO_MIN;
            if (quot > tte_pkg::TEMPO_MAX)
                quot = tte_pkg::TEMPO_MAX;
            res.channel = ch;
            res.tempo   = quot[TEMPO_W-1:0];
            expected_tempos.push_back(res);
        endfunction

        function void check_tempo(logic [CH_W-1:0] ch, logic [TEMPO_W-1:0] tempo);
            tempo_result_t want;
            if (expected_tempos.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual channel %0d tempo %0d",
                         $time, ch, tempo);
                errors++;
                return;
            end
            want = expected_tempos.pop_front();
            if (want.channel !== ch)
            begin
                $display("%0t: channel mismatch, expected %0d, actual %0d",
                         $time, want.channel, ch);
                errors++;
            end
            if (want.tempo !== tempo)
            begin
                $display("%0t: tempo mismatch on channel %0d, expected %0d, actual %0d",
                         $time, want.channel, want.tempo, tempo);
                errors++;
            end
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [IN_W-1:0]                 s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [OUT_W-1:0]                m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [tte_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]                cfg_data = '0;

    tap_tempo_tracker  tracker = new();
    flow_t             flow = FLOW_FREE;
    int                hold_left = 0;
    logic [TIME_W-1:0] stim_time [NCH] = '{default: '0};

    tap_tempo_estimator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic int send_gap_pct();
        case (flow)
            FLOW_SEND_GAPS: return 66;
            FLOW_BOTH:      return 34;
            default:        return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct();
        case (flow)
            FLOW_RECV_STALLS: return 66;
            FLOW_BOTH:        return 34;
            default:          return 0;
        endcase
    endfunction

    task automatic send_tap(input logic [CH_W-1:0] ch, input logic [TIME_W-1:0] t);
        while ($urandom_range(99) < send_gap_pct())
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - CH_W - TIME_W){1'b0}}, t, ch};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tracker.note_tap(ch, t);
        if (ch < NCH)
            stim_time[ch] = t;
    endtask

    task automatic send_after(input logic [CH_W-1:0] ch, input logic [TIME_W-1:0] gap);
        send_tap(ch, stim_time[ch] + gap);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_limits(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
        cfg_valid <= 1'b1;
        cfg_index <= tte_pkg::CFG_MIN_INTERVAL;
        cfg_data  <= lo;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.set_limit(tte_pkg::CFG_MIN_INTERVAL, lo);
        cfg_index <= tte_pkg::CFG_MAX_INTERVAL;
        cfg_data  <= hi;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.set_limit(tte_pkg::CFG_MAX_INTERVAL, hi);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_tap(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
        int                pick;
        logic [CH_W-1:0]   ch;
        logic [TIME_W-1:0] gap;
        pick = $urandom_range(99);
        if (pick < 3)
        begin
            send_tap(2'd3, $urandom);
            return;
        end
        ch   = $urandom_range(NCH - 1);
        pick = $urandom_range(99);
        if (pick < 80 && lo <= hi)
            gap = $urandom_range(hi, lo);
        else if (pick < 85)
            gap = lo - 1;
        else if (pick < 90)
            gap = hi + 1;
        else if (pick < 95)
            gap = $urandom;
        else
            gap = $urandom_range(4200);
        send_after(ch, gap);
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                tracker.check_tempo(m_tdata[CH_W-1:0], m_tdata[CH_W+TEMPO_W-1:CH_W]);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct());
        end
    end

    initial
    begin
        repeat (CYCLE_CAP) @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        logic [CFG_W-1:0] lo_set [8];
        logic [CFG_W-1:0] hi_set [8];
        lo_set = '{12'd100, 12'd300, 12'd1,    12'd4095, 12'd2000, 12'd200, 12'd1,  12'd600};
        hi_set = '{12'd3000, 12'd1500, 12'd4095, 12'd4095, 12'd1000, 12'd800, 12'd60, 12'd2400};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send_tap(2'd3, $urandom);
        send_tap(2'd0, 32'd0);
        send_tap(2'd0, 32'd500);
        send_tap(2'd0, 32'd1000);
        send_tap(2'd0, 32'd1100);
        send_tap(2'd0, 32'd4100);
        send_tap(2'd0, 32'd7101);
        send_tap(2'd0, 32'd7200);
        send_tap(2'd0, 32'd7300);
        send_tap(2'd0, 32'd7400);
        send_tap(2'd1, 32'hFFFF_FF00);
        send_tap(2'd1, 32'h0000_0064);
        send_tap(2'd1, 32'h0000_01C8);
        send_tap(2'd1, 32'hFFFF_FFFF);
        send_tap(2'd2, 32'hFFFF_FFFF);
        send_after(2'd2, 32'd3000);
        send_after(2'd2, 32'd3000);
        repeat (5) send_after(2'd2, 32'd500);
        settle();

        // With no lower limit, repeated taps at one instant store zero-length intervals in the history.
        write_limits(12'd0, 12'd4095);
        send_after(2'd0, 32'd0);
        send_after(2'd0, 32'd0);
        send_after(2'd0, 32'd1);
        settle();

        for (int p = 0; p < 8; p++)
        begin
            write_limits(lo_set[p], hi_set[p]);
            flow = flow_t'(p % 4);
            if (p == 0)
                hold_left = 600;
            repeat (PHASE_ITEMS) random_tap(lo_set[p], hi_set[p]);
            settle();
        end

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/tte_pkg.sv
rtl/tte_serial_sub.sv
rtl/tte_ring.sv
rtl/tte_divider.sv
rtl/tap_tempo_estimator.sv
tb/sv/tap_tempo_estimator_test.sv
